/* hw/rtl/ncc_pkg.sv */
`default_nettype none

package ncc_pkg;

  // Default sizing of the stored tables.
  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_FEATURES = 1024;

  // Field widths.
  localparam int VALUE_W = 16;
  localparam int ACC_W   = 42;
  localparam int CNT_W   = 32;
  localparam int LABEL_W = 4;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
  localparam logic [ACC_W-1:0] ACC_MAX   = '1;

  // Request codes on req_type.
  typedef enum logic [1:0] {
    REQ_LOAD_CEN   = 2'd0,
    REQ_LOAD_CLASS = 2'd1,
    REQ_QUERY      = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_DRAIN,
    ST_CLASS,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the accumulator unit.
  typedef struct packed {
    logic issue;  // read one accumulator entry this cycle
    logic clear;  // drop all accumulators back to zero
  } acc_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/nearest_centroid_classifier.sv */
`default_nettype none

// Nearest-centroid classifier. Issue one request per start pulse while busy is
// low: load a centroid element, load a cluster's class, stream one query
// feature, or clear the counts. Loads and clears finish in the accepting cycle
// and leave busy low. A query feature holds busy while it walks the n clusters
// in use (cfg register, 0 treated as 1, capped at MAX_CLUSTERS), one cluster
// per cycle through the single read port of the accumulator memory, and then
// drains the three-stage multiply/add/compare pipeline. The feature flagged
// last_feature also adds a class-table read and a result state. The result
// appears for exactly one cycle with done high and cannot be held off;
// capture it then. correct_count and query_count are live and read as the
// post-query values in that cycle. Accumulators reset to zero at once
// (per-entry valid bits), so no clearing pass is needed after reset.
// Centroid and class entries never loaded read back as unknown.
module nearest_centroid_classifier #(
  parameter int MAX_CLUSTERS = ncc_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_FEATURES = ncc_pkg::DEF_MAX_FEATURES
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: clusters in use
  input  logic                        cfg_wen,
  input  logic [ncc_pkg::CFG_W-1:0]   cfg_wdata,
  // request side
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [3:0]                  cluster_index,
  input  logic [9:0]                  feature_index,
  input  logic [ncc_pkg::VALUE_W-1:0] value,
  input  logic [ncc_pkg::LABEL_W-1:0] class_label,
  input  logic                        last_feature,
  // result side
  output logic                        done,
  output logic [3:0]                  nearest_cluster,
  output logic [ncc_pkg::ACC_W-1:0]   best_distance_sq,
  output logic [ncc_pkg::LABEL_W-1:0] predicted_class,
  output logic                        is_correct,
  output logic [ncc_pkg::CNT_W-1:0]   correct_count,
  output logic [ncc_pkg::CNT_W-1:0]   query_count
);

  localparam int CW    = $clog2(MAX_CLUSTERS);
  localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int DEPTH = MAX_CLUSTERS * MAX_FEATURES;
  localparam int MW    = $clog2(DEPTH);
  localparam int VW    = ncc_pkg::VALUE_W;
  localparam int LW    = ncc_pkg::LABEL_W;
  localparam int NW    = ncc_pkg::CNT_W;

  ncc_pkg::state_t state, state_next;
  ncc_pkg::req_t   req;
  ncc_pkg::acc_ctl_t acc_ctl;

  logic [ncc_pkg::CFG_W-1:0] clusters_in_use;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] cidx;
  logic [FW-1:0] pos;
  logic [VW-1:0] value_q;
  logic [LW-1:0] label_q;
  logic          last_q;

  // Centroid store: one row of MAX_FEATURES elements per cluster.
  logic [VW-1:0] cen_mem [DEPTH];
  logic [VW-1:0] cen_rd;
  logic [MW-1:0] cen_wr_addr;
  logic [MW-1:0] cen_rd_addr;

  // Class per cluster.
  logic [LW-1:0] class_mem [MAX_CLUSTERS];
  logic [LW-1:0] class_rd;

  logic [NW-1:0] hits_total;
  logic [NW-1:0] queries_total;

  logic req_accept, ld_cen, ld_class, clr_accept, q_accept;
  logic pass_end, hit;
  logic issue, class_rd_en, emit;

  logic                      pipe_busy;
  logic [CW-1:0]             best_idx;
  logic [ncc_pkg::ACC_W-1:0] best_dist;

  // ---------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------
  assign req        = ncc_pkg::req_t'(req_type);
  assign req_accept = start && !busy;
  assign ld_cen     = req_accept && (req == ncc_pkg::REQ_LOAD_CEN)
                      && (32'(cluster_index) < MAX_CLUSTERS)
                      && (32'(feature_index) < MAX_FEATURES);
  assign ld_class   = req_accept && (req == ncc_pkg::REQ_LOAD_CLASS)
                      && (32'(cluster_index) < MAX_CLUSTERS);
  assign clr_accept = req_accept && (req == ncc_pkg::REQ_CLEAR);
  assign q_accept   = req_accept && (req == ncc_pkg::REQ_QUERY);

  // Highest cluster index walked per feature; 0 acts as 1, large values cap.
  always_comb begin
    if (clusters_in_use == '0) begin
      last_idx = '0;
    end else if (32'(clusters_in_use) > MAX_CLUSTERS) begin
      last_idx = CW'(MAX_CLUSTERS - 1);
    end else begin
      last_idx = CW'(32'(clusters_in_use) - 32'd1);
    end
  end

  assign pass_end    = (state == ncc_pkg::ST_PASS) && (cidx == last_idx);
  assign cen_wr_addr = MW'(32'(cluster_index) * 32'(MAX_FEATURES) + 32'(feature_index));
  assign cen_rd_addr = MW'(32'(cidx) * 32'(MAX_FEATURES) + 32'(pos));

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ncc_pkg::ST_IDLE: begin
        if (q_accept) state_next = ncc_pkg::ST_PASS;
      end
      ncc_pkg::ST_PASS: begin
        if (cidx == last_idx) state_next = ncc_pkg::ST_DRAIN;
      end
      ncc_pkg::ST_DRAIN: begin
        // wait for the last write-back and min update
        if (!pipe_busy) state_next = last_q ? ncc_pkg::ST_CLASS : ncc_pkg::ST_IDLE;
      end
      ncc_pkg::ST_CLASS: state_next = ncc_pkg::ST_EMIT;
      ncc_pkg::ST_EMIT:  state_next = ncc_pkg::ST_IDLE;
      default:           state_next = ncc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    issue       = 1'b0;
    class_rd_en = 1'b0;
    emit        = 1'b0;
    unique case (state)
      ncc_pkg::ST_IDLE:  busy        = 1'b0;
      ncc_pkg::ST_PASS:  issue       = 1'b1;
      ncc_pkg::ST_DRAIN: busy        = 1'b1;
      ncc_pkg::ST_CLASS: class_rd_en = 1'b1;
      ncc_pkg::ST_EMIT:  emit        = 1'b1;
      default:           busy        = 1'b1;
    endcase
  end

  assign acc_ctl.issue = issue;
  assign acc_ctl.clear = emit;   // query done: all accumulators back to zero

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ncc_pkg::ST_IDLE;
      clusters_in_use <= ncc_pkg::CFG_RESET;
      pos             <= '0;
      cidx            <= '0;
      hits_total      <= '0;
      queries_total   <= '0;
      done            <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
      if (cfg_wen) clusters_in_use <= cfg_wdata;

      // cluster walk for one feature
      if (q_accept) begin
        cidx <= '0;
      end else if (issue && !pass_end) begin
        cidx <= cidx + 1'b1;
      end

      // feature position: wraps at MAX_FEATURES, back to zero after a query
      if (pass_end) begin
        if (last_q || 32'(pos) == MAX_FEATURES - 1) begin
          pos <= '0;
        end else begin
          pos <= pos + 1'b1;
        end
      end

      // saturating counts; clear only happens while idle
      if (clr_accept) begin
        hits_total    <= '0;
        queries_total <= '0;
      end else if (emit) begin
        if (hit && hits_total != '1) hits_total <= hits_total + 1'b1;
        if (queries_total != '1)     queries_total <= queries_total + 1'b1;
      end
    end
  end

  // Query operands held for the whole walk.
  always_ff @(posedge clk) begin
    if (q_accept) begin
      value_q <= value;
      label_q <= class_label;
      last_q  <= last_feature;
    end
  end

  // ---------------------------------------------------------------------
  // Tables
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld_cen) cen_mem[cen_wr_addr] <= value;
    if (issue)  cen_rd <= cen_mem[cen_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ld_class)    class_mem[CW'(cluster_index)] <= class_label;
    if (class_rd_en) class_rd <= class_mem[best_idx];
  end

  // ---------------------------------------------------------------------
  // Distance accumulation and nearest pick
  // ---------------------------------------------------------------------
  ncc_accum #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .ctl       (acc_ctl),
    .idx       (cidx),
    .feat      (value_q),
    .cen       (cen_rd),
    .pipe_busy (pipe_busy),
    .best_idx  (best_idx),
    .best_dist (best_dist)
  );

  // ---------------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------------
  assign hit = (class_rd == label_q);

  always_ff @(posedge clk) begin
    if (emit) begin
      nearest_cluster  <= 4'(best_idx);
      best_distance_sq <= best_dist;
      predicted_class  <= class_rd;
      is_correct       <= hit;
    end
  end

  assign correct_count = hits_total;
  assign query_count   = queries_total;

`ifndef NO_ASSERTIONS
  // a result only follows the result state
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ncc_pkg::ST_EMIT))
    else $error("result strobe without a finished query");

  // nearest pick only after all accumulator writes have landed
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ncc_pkg::ST_CLASS) |-> !pipe_busy)
    else $error("class read with accumulator pipeline in flight");

  // query count moves only on a result or a clear
  a_cnt_src: assert property (@(posedge clk) disable iff (rst)
    (queries_total != $past(queries_total)) |->
      ($past(state == ncc_pkg::ST_EMIT) || $past(clr_accept)))
    else $error("query count changed without cause");

  // no memory walk while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ncc_pkg::ST_IDLE) |-> !issue && !busy)
    else $error("walk issued while idle");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ncc_accum.sv */
`default_nettype none

// Accumulator memory with a read-modify-write pipeline and running minimum.
// S1: memory data in, |diff|^2.  S2: saturating add, write back.  S3: min.
module ncc_accum #(
  parameter int MAX_CLUSTERS = ncc_pkg::DEF_MAX_CLUSTERS,
  localparam int CW = $clog2(MAX_CLUSTERS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ncc_pkg::acc_ctl_t           ctl,
  input  logic [CW-1:0]               idx,
  input  logic [ncc_pkg::VALUE_W-1:0] feat,
  input  logic [ncc_pkg::VALUE_W-1:0] cen,
  output logic                        pipe_busy,
  output logic [CW-1:0]               best_idx,
  output logic [ncc_pkg::ACC_W-1:0]   best_dist
);

  localparam int VW = ncc_pkg::VALUE_W;
  localparam int AW = ncc_pkg::ACC_W;

  logic [AW-1:0]           acc_mem [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] vld;

  // S1
  logic          v1;
  logic [CW-1:0] idx1;
  logic [AW-1:0] acc_rd;
  logic          vld1;
  logic [VW:0]   diff;
  logic [VW-1:0] absd;
  logic [2*VW-1:0] sq1;

  // S2
  logic          v2;
  logic [CW-1:0] idx2;
  logic [2*VW-1:0] sq2;
  logic [AW-1:0] acc2;
  logic [AW:0]   sum;
  logic [AW-1:0] acc_new;

  // S3
  logic          v3;
  logic [CW-1:0] idx3;
  logic [AW-1:0] acc3;

  assign diff = {1'b0, cen} - {1'b0, feat};
  assign absd = diff[VW] ? VW'(~diff + 1'b1) : diff[VW-1:0];
  assign sq1  = (2*VW)'(absd) * (2*VW)'(absd);

  assign sum     = (AW+1)'(acc2) + (AW+1)'(sq2);
  assign acc_new = sum[AW] ? ncc_pkg::ACC_MAX : sum[AW-1:0];

  assign pipe_busy = v1 | v2 | v3;

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      acc_rd <= acc_mem[idx];
      vld1   <= vld[idx];
    end
    if (v2) begin
      acc_mem[idx2] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      vld <= '0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2;
      if (ctl.clear) begin
        vld <= '0;
      end else if (v2) begin
        vld[idx2] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= idx;
    idx2 <= idx1;
    sq2  <= sq1;
    acc2 <= vld1 ? acc_rd : '0;
    idx3 <= idx2;
    acc3 <= acc_new;
    // strict less-than in index order: lowest index wins a tie
    if (v3 && (idx3 == '0 || acc3 < best_dist)) begin
      best_idx  <= idx3;
      best_dist <= acc3;
    end
  end

endmodule

`default_nettype wire
